[rtl/ngp_pkg.sv]
// ----------------------------------------------------------------------------
// ngp_pkg
// Shared types and constants of the NGP grid moment accumulator.
// ----------------------------------------------------------------------------
package ngp_pkg;

	localparam int GRID_SIDE_MAX = 32;
	localparam int SLICE_MAX     = 4;
	localparam int CELLS         = SLICE_MAX * GRID_SIDE_MAX * GRID_SIDE_MAX;
	localparam int CELL_AW       = $clog2(CELLS);

	localparam logic [1:0] REG_GRID_SIDE   = 2'd0;
	localparam logic [1:0] REG_SLICE_DEPTH = 2'd1;
	localparam logic [1:0] REG_SLICE_START = 2'd2;
	localparam logic [1:0] REG_SCALE_RATIO = 2'd3;

	localparam logic OP_DEPOSIT = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef struct packed {
		logic               operation;
		logic        [23:0] pos_x;
		logic        [23:0] pos_y;
		logic        [23:0] pos_z;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic signed [23:0] vel_z;
		logic        [11:0] cell_index;
	} in_word_t;

	typedef struct packed {
		logic               accepted;
		logic        [15:0] cell_count;
		logic signed [31:0] slope_x;
		logic signed [31:0] slope_y;
		logic signed [31:0] slope_z;
		logic        [2:0]  degenerate_mask;
		logic        [31:0] used_total;
	} out_word_t;

	typedef struct packed {
		logic        [47:0] osum;
		logic signed [47:0] vsum;
		logic        [63:0] osq;
		logic signed [63:0] ovel;
	} axis_sum_t;

	typedef struct packed {
		logic      [15:0]      count;
		axis_sum_t [2:0]       axis;
	} cell_entry_t;

	typedef struct packed {
		logic [2:0][31:0] slope;
		logic [2:0]       mask;
	} slope_res_t;

endpackage

[rtl/ngp_grid_moment_accumulator.sv]
// ----------------------------------------------------------------------------
// ngp_grid_moment_accumulator
// Nearest-grid-point deposit of particle moments into a cell memory, with
// read-and-clear of one cell returning count and per-axis velocity slopes.
// ----------------------------------------------------------------------------
// Deposit: one word at a time through S_DEP_MUL, S_DEP_RD and S_DEP_WR (memory RMW).
// Read-and-clear: the slope unit runs the shared multiplier and the
//   one-bit-per-cycle divider per axis; a degenerate axis skips the divider.
// A new word is accepted while a finished result still waits on the output.
// Reset: a clearing pass over all 4096 cells zeroes the cell memory; no words are
//   accepted meanwhile, register writes are taken at any time.
module ngp_grid_moment_accumulator import ngp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data
);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DEP_MUL, S_DEP_RD, S_DEP_WR, S_RD_CLR, S_RD_WAIT, S_OUT
	} state_t;

	state_t              state_q;
	logic [CELL_AW-1:0]  clr_q;
	logic [5:0]          grid_side_q;
	logic [2:0]          slice_depth_q;
	logic [4:0]          slice_start_q;
	logic [23:0]         scale_ratio_q;
	logic [31:0]         used_q;
	logic                out_valid_q;

	in_word_t            in_q;
	logic [47:0]         g_s1 [3];
	logic [15:0]         frac_s2 [3];
	logic [31:0]         fsq_s2 [3];
	logic signed [40:0]  fv_s2 [3];
	logic                ok_s2;
	logic [CELL_AW-1:0]  loc_s2;
	out_word_t           res_q;
	out_word_t           out_q;

	cell_entry_t         mem [CELLS];
	cell_entry_t         rd_q;
	logic                mem_we, mem_re;
	logic [CELL_AW-1:0]  mem_addr;
	cell_entry_t         mem_wd;

	logic                in_acc, cfg_wr;
	logic [23:0]         pos_a [3];
	logic signed [23:0]  vel_a [3];
	logic [5:0]          side_c;
	logic [2:0]          depth_c;
	logic [19:0]         cell_a [3];
	logic [15:0]         frac_a [3];
	logic [19:0]         xoff;
	logic                ok_c;
	logic [CELL_AW-1:0]  loc_c;
	logic                dep_add;
	cell_entry_t         dep_entry;

	logic                slope_start, slope_done;
	slope_res_t          slope_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		unique case (paddr[3:2])
			REG_GRID_SIDE:   prdata = {26'b0, grid_side_q};
			REG_SLICE_DEPTH: prdata = {29'b0, slice_depth_q};
			REG_SLICE_START: prdata = {27'b0, slice_start_q};
			default:         prdata = {8'b0, scale_ratio_q};
		endcase
	end

	always_comb begin
		pos_a[0] = in_q.pos_x;
		pos_a[1] = in_q.pos_y;
		pos_a[2] = in_q.pos_z;
		vel_a[0] = in_q.vel_x;
		vel_a[1] = in_q.vel_y;
		vel_a[2] = in_q.vel_z;
		if (grid_side_q == '0)
			side_c = 6'd1;
		else if (grid_side_q > 6'(GRID_SIDE_MAX))
			side_c = 6'(GRID_SIDE_MAX);
		else
			side_c = grid_side_q;
		if (slice_depth_q == '0)
			depth_c = 3'd1;
		else if (slice_depth_q > 3'(SLICE_MAX))
			depth_c = 3'(SLICE_MAX);
		else
			depth_c = slice_depth_q;
		for (int a = 0; a < 3; a++) begin
			cell_a[a] = g_s1[a][47:28];
			frac_a[a] = g_s1[a][27:12];
		end
		xoff = cell_a[0] - {15'b0, slice_start_q};
		ok_c = (cell_a[0] >= {15'b0, slice_start_q}) && (xoff < {17'b0, depth_c})
			&& (cell_a[0] < {14'b0, side_c}) && (cell_a[1] < {14'b0, side_c})
			&& (cell_a[2] < {14'b0, side_c});
		loc_c = CELL_AW'((CELL_AW'(xoff[1:0]) * CELL_AW'(side_c) + CELL_AW'(cell_a[1][4:0]))
			* CELL_AW'(side_c) + CELL_AW'(cell_a[2][4:0]));
	end

	always_comb begin
		dep_add = ok_s2 && (rd_q.count != 16'hFFFF);
		dep_entry.count = rd_q.count + 16'd1;
		for (int a = 0; a < 3; a++) begin
			dep_entry.axis[a].osum = rd_q.axis[a].osum + {32'b0, frac_s2[a]};
			dep_entry.axis[a].vsum = rd_q.axis[a].vsum + 48'(vel_a[a]);
			dep_entry.axis[a].osq  = rd_q.axis[a].osq + {32'b0, fsq_s2[a]};
			dep_entry.axis[a].ovel = rd_q.axis[a].ovel + 64'(fv_s2[a]);
		end
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = loc_c;
		mem_wd   = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_IDLE: begin
				mem_re   = in_acc;
				mem_addr = in_data.cell_index;
			end
			S_DEP_RD: mem_re = 1'b1;
			S_DEP_WR: begin
				mem_we   = dep_add;
				mem_addr = loc_s2;
				mem_wd   = dep_entry;
			end
			S_RD_CLR: begin
				mem_we   = 1'b1;
				mem_addr = in_q.cell_index;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wd;
		if (mem_re)
			rd_q <= mem[mem_addr];
	end

	assign slope_start = (state_q == S_RD_CLR);

	ngp_slope_unit u_slope (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (slope_start),
		.entry  (rd_q),
		.done   (slope_done),
		.result (slope_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			grid_side_q   <= 6'd32;
			slice_depth_q <= 3'd4;
			slice_start_q <= 5'd0;
			scale_ratio_q <= 24'h01_0000;
			used_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_GRID_SIDE:   grid_side_q   <= pwdata[5:0];
					REG_SLICE_DEPTH: slice_depth_q <= pwdata[2:0];
					REG_SLICE_START: slice_start_q <= pwdata[4:0];
					default:         scale_ratio_q <= pwdata[23:0];
				endcase
			end
			if (state_q == S_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CELL_AW'(1);
					if (clr_q == CELL_AW'(CELLS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc)
						state_q <= (in_data.operation == OP_READ) ? S_RD_CLR : S_DEP_MUL;
				end
				S_DEP_MUL: state_q <= S_DEP_RD;
				S_DEP_RD:  state_q <= S_DEP_WR;
				S_DEP_WR: begin
					used_q  <= used_q + {31'b0, dep_add};
					state_q <= S_OUT;
				end
				S_RD_CLR: state_q <= S_RD_WAIT;
				S_RD_WAIT: begin
					if (slope_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc)
					in_q <= in_data;
			end
			S_DEP_MUL: begin
				for (int a = 0; a < 3; a++)
					g_s1[a] <= pos_a[a] * scale_ratio_q;
			end
			S_DEP_RD: begin
				ok_s2  <= ok_c;
				loc_s2 <= loc_c;
				for (int a = 0; a < 3; a++) begin
					frac_s2[a] <= frac_a[a];
					fsq_s2[a]  <= frac_a[a] * frac_a[a];
					fv_s2[a]   <= $signed({1'b0, frac_a[a]}) * vel_a[a];
				end
			end
			S_DEP_WR: begin
				res_q <= '{accepted: dep_add, cell_count: '0, slope_x: '0, slope_y: '0,
					slope_z: '0, degenerate_mask: '0,
					used_total: used_q + {31'b0, dep_add}};
			end
			S_RD_CLR: begin
				res_q <= '{accepted: 1'b0, cell_count: rd_q.count, slope_x: '0,
					slope_y: '0, slope_z: '0, degenerate_mask: '0, used_total: used_q};
			end
			S_RD_WAIT: begin
				if (slope_done) begin
					res_q.slope_x         <= slope_res.slope[0];
					res_q.slope_y         <= slope_res.slope[1];
					res_q.slope_z         <= slope_res.slope[2];
					res_q.degenerate_mask <= slope_res.mask;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall)
					out_q <= res_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_mem_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("cell memory read and write in one cycle");

	a_slope_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		slope_done |-> (state_q == S_RD_WAIT))
		else $error("slope result outside read wait");

	a_used_from_deposit: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> ($past(state_q) == S_DEP_WR))
		else $error("accepted count moved outside deposit write");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (in_stall && !out_valid))
		else $error("input open during clearing pass");
`endif

endmodule

[rtl/ngp_slope_unit.sv]
// ----------------------------------------------------------------------------
// ngp_slope_unit
// Per-axis velocity slope of one cell: shared 32x32 multiplier for the
// moment products, restoring divider one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ngp_slope_unit import ngp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cell_entry_t entry,
	output logic        done,
	output slope_res_t  result
);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_ACC, S_PROD, S_SETUP, S_DIV, S_SAT, S_NEXT
	} state_t;

	state_t       state_q;
	cell_entry_t  ent_q;
	logic [1:0]   axis_q;
	logic [1:0]   prod_k_q;
	logic [1:0]   part_q;
	logic [6:0]   bit_q;
	logic         done_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [63:0]  prod_q;
	logic [63:0]  den_q;
	logic [127:0] num_q;
	logic [63:0]  rem_q;
	logic [127:0] dvd_q;
	logic [127:0] quo_q;
	slope_res_t   res_q;

	axis_sum_t    cur;
	logic [63:0]  n64, sx64, sv64, sv_mag, sxv_mag, opa, opb;
	logic         sv_neg, sxv_neg, sub_sel;
	logic [31:0]  a_half, b_half;
	logic [63:0]  partial;
	logic [6:0]   shamt;
	logic [127:0] shifted, base, mag;
	logic [63:0]  rem_sh;
	logic         qbit;
	logic [31:0]  sat_val;

	always_comb begin
		cur     = ent_q.axis[axis_q];
		n64     = {48'b0, ent_q.count};
		sx64    = {16'b0, cur.osum};
		sv64    = 64'(cur.vsum);
		sv_neg  = cur.vsum[47];
		sv_mag  = sv_neg ? 64'(64'd0 - sv64) : sv64;
		sxv_neg = cur.ovel[63];
		sxv_mag = sxv_neg ? 64'(64'd0 - cur.ovel) : cur.ovel;
		unique case (prod_k_q)
			2'd0: begin opa = n64;  opb = cur.osq; end
			2'd1: begin opa = sx64; opb = sx64;    end
			2'd2: begin opa = n64;  opb = sxv_mag; end
			default: begin opa = sx64; opb = sv_mag; end
		endcase
		a_half  = part_q[1] ? opa[63:32] : opa[31:0];
		b_half  = part_q[0] ? opb[63:32] : opb[31:0];
		shamt   = {({1'b0, part_q[1]} + {1'b0, part_q[0]}), 5'b0};
		shifted = {64'b0, prod_q} << shamt;
		base    = (prod_k_q == 2'd2) ? 128'd0 : num_q;
		sub_sel = (prod_k_q == 2'd2) ? sxv_neg : !sv_neg;
		mag     = num_q[127] ? 128'(128'd0 - num_q) : num_q;
		rem_sh  = {rem_q[62:0], dvd_q[127]};
		qbit    = rem_q[63] || (rem_sh >= den_q);
		if (neg_q) begin
			if (quo_q[127:32] != '0 || quo_q[31:0] > 32'h8000_0000)
				sat_val = 32'h8000_0000;
			else
				sat_val = 32'(32'd0 - quo_q[31:0]);
		end else begin
			if (quo_q[127:31] != '0)
				sat_val = 32'h7FFF_FFFF;
			else
				sat_val = quo_q[31:0];
		end
	end

	assign partial = a_half * b_half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			axis_q   <= '0;
			prod_k_q <= '0;
			part_q   <= '0;
			bit_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						axis_q   <= '0;
						prod_k_q <= '0;
						part_q   <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					part_q  <= part_q + 2'd1;
					state_q <= (part_q == 2'd3) ? S_PROD : S_MUL;
				end
				S_PROD: begin
					prod_k_q <= prod_k_q + 2'd1;
					state_q  <= (prod_k_q == 2'd3) ? S_SETUP : S_MUL;
				end
				S_SETUP: begin
					bit_q   <= '0;
					state_q <= (den_q == '0) ? S_NEXT : S_DIV;
				end
				S_DIV: begin
					bit_q <= bit_q + 7'd1;
					if (bit_q == 7'd127)
						state_q <= S_SAT;
				end
				S_SAT: state_q <= S_NEXT;
				S_NEXT: begin
					prod_k_q <= '0;
					part_q   <= '0;
					if (axis_q == 2'd2) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ent_q <= entry;
					acc_q <= '0;
					res_q <= '0;
				end
			end
			S_MUL: prod_q <= partial;
			S_ACC: acc_q <= acc_q + shifted;
			S_PROD: begin
				acc_q <= '0;
				unique case (prod_k_q)
					2'd0: den_q <= acc_q[63:0];
					2'd1: den_q <= den_q - acc_q[63:0];
					default: num_q <= sub_sel ? 128'(base - acc_q) : 128'(base + acc_q);
				endcase
			end
			S_SETUP: begin
				rem_q <= '0;
				quo_q <= '0;
				dvd_q <= mag << 24;
				neg_q <= num_q[127];
				if (den_q == '0) begin
					res_q.mask[axis_q]  <= 1'b1;
					res_q.slope[axis_q] <= '0;
				end
			end
			S_DIV: begin
				rem_q <= qbit ? 64'(rem_sh - den_q) : rem_sh;
				quo_q <= {quo_q[126:0], qbit};
				dvd_q <= {dvd_q[126:0], 1'b0};
			end
			S_SAT: res_q.slope[axis_q] <= sat_val;
			S_NEXT: acc_q <= '0;
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
